@@ sv/gsv_pkg.sv @@
package gsv_pkg;

  // Grid size and field widths.
  localparam int MAX_DIMS = 4;
  localparam int DIM_W    = 2;
  localparam int CFG_W    = 3;
  localparam int VAL_W    = 32;
  localparam int STEP_W   = 16;

  // Interpolation datapath: index times span, then a one-sided divide.
  localparam int PROD_W          = VAL_W + 1 + STEP_W;
  localparam int MAG_W           = PROD_W - 1;
  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_STEPS       = MAG_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  // Queue sizes.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;
  localparam int CMDQ_CNT_W = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ORDER   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NEXT    = 2'd3
  } gsv_op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PERM    = 2'd1,
    ST_NOT_STARTED = 2'd2
  } gsv_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_DIFF,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT,
    S_ADV
  } gsv_state_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [DIM_W-1:0]        slot_index;
    logic signed [VAL_W-1:0] start_value;
    logic signed [VAL_W-1:0] end_value;
    logic [STEP_W-1:0]       step_total;
    logic [DIM_W-1:0]        order_dimension;
  } gsv_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element_value;
    logic [DIM_W-1:0]        element_dimension;
    logic                    last_element;
    logic                    sweep_done;
    logic [1:0]              status;
  } gsv_out_t;

  typedef struct packed {
    gsv_op_e           op;
    logic [DIM_W-1:0]  slot;
    logic [VAL_W-1:0]  start_value;
    logic [VAL_W-1:0]  end_value;
    logic [STEP_W-1:0] step_total;
    logic [DIM_W-1:0]  order_dim;
  } gsv_cmd_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  dividend;
    logic [STEP_W-1:0] divisor;
  } gsv_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAG_W-1:0] quotient;
  } gsv_div_rsp_t;

endpackage

@@ sv/gsv_front.sv @@
module gsv_front import gsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  gsv_in_t  in_data_i,
  output logic     full,
  input  logic     cmd_pop_i,
  output logic     cmd_valid_o,
  output gsv_cmd_t cmd_o
);

  gsv_cmd_t              cmdq_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_q, wr_d;
  logic [CMDQ_PTR_W-1:0] rd_q, rd_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  gsv_cmd_t              cmd_in;
  logic                  push_ok;
  logic                  pop_ok;

  // Decode the raw item into an internal command.
  always_comb begin
    cmd_in.op          = gsv_op_e'(in_data_i.opcode);
    cmd_in.slot        = in_data_i.slot_index;
    cmd_in.start_value = in_data_i.start_value;
    cmd_in.end_value   = in_data_i.end_value;
    cmd_in.step_total  = in_data_i.step_total;
    cmd_in.order_dim   = in_data_i.order_dimension;
  end

  assign full        = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmdq_q[rd_q];
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_d  = push_ok ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_ok ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      cmdq_q[wr_q] <= cmd_in;
    end
  end

endmodule

@@ sv/gsv_div.sv @@
module gsv_div import gsv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gsv_div_req_t req_i,
  output gsv_div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [MAG_W-1:0]     rq_q, rq_d;
  logic [STEP_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0]    dsr_q;
  logic [STEP_W:0]      r1, r2;
  logic                 ge1, ge2;
  logic [STEP_W-1:0]    rem1;
  logic [MAG_W-1:0]     rq1;

  // Two restoring steps per cycle; the dividend shifts out at the top while
  // quotient bits shift in at the bottom.
  always_comb begin
    r1   = {rem_q, rq_q[MAG_W-1]};
    ge1  = (r1 >= {1'b0, dsr_q});
    rem1 = ge1 ? STEP_W'(r1 - {1'b0, dsr_q}) : r1[STEP_W-1:0];
    rq1  = {rq_q[MAG_W-2:0], ge1};
    r2   = {rem1, rq1[MAG_W-1]};
    ge2  = (r2 >= {1'b0, dsr_q});
    rem_d = ge2 ? STEP_W'(r2 - {1'b0, dsr_q}) : r2[STEP_W-1:0];
    rq_d  = {rq1[MAG_W-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rq_q  <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rq_q  <= rq_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = rq_q;

endmodule

@@ sv/gsv_back.sv @@
module gsv_back import gsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             cmd_valid_i,
  input  gsv_cmd_t         cmd_i,
  output logic             cmd_pop_o,
  output gsv_div_req_t     div_req_o,
  input  gsv_div_rsp_t     div_rsp_i,
  input  logic             pop,
  output logic             empty,
  output gsv_out_t         out_data_o
);

  // Dimension tables, order table and point counters.
  logic [VAL_W-1:0]  start_q [MAX_DIMS];
  logic [VAL_W-1:0]  end_q   [MAX_DIMS];
  logic [STEP_W-1:0] step_q  [MAX_DIMS];
  logic [DIM_W-1:0]  order_q [MAX_DIMS];
  logic [STEP_W-1:0] count_q [MAX_DIMS];

  logic             ready_q;
  logic [CFG_W-1:0] dim_cnt_q;
  gsv_state_e       state_q, state_d;
  logic [DIM_W-1:0] pos_q;
  logic             carry_q;

  // Per-element datapath registers.
  gsv_out_t                res_q, res_d;
  logic [VAL_W-1:0]        s_q;
  logic signed [VAL_W:0]   diff_q;
  logic [STEP_W-1:0]       idx_q;
  logic [STEP_W-1:0]       dsr_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    neg_q;
  logic [VAL_W-1:0]        qs_q;

  // Result queue.
  gsv_out_t              outq_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] oq_wr_q;
  logic [OUTQ_PTR_W-1:0] oq_rd_q;
  logic [OUTQ_CNT_W-1:0] oq_cnt_q;
  logic                  oq_full;
  logic                  oq_pop;

  logic              push_en;
  gsv_out_t          push_data;
  gsv_out_t          elem;
  logic [DIM_W-1:0]  last_pos;
  logic [DIM_W-1:0]  ord_pos;
  logic [DIM_W-1:0]  ord_dim;
  logic [DIM_W-1:0]  sel_dim;
  logic [STEP_W-1:0] sel_cnt;
  logic [STEP_W-1:0] sel_step;
  logic [VAL_W-1:0]  sel_start;
  logic [VAL_W-1:0]  sel_end;
  logic              slow_fin;
  logic              perm_ok;
  logic              small_span;
  logic [STEP_W-1:0] adv_val;
  logic              adv_wrap;
  logic              is_last;
  logic signed [PROD_W:0]  prod_full;
  logic [PROD_W-1:0]       prod_neg;
  logic [VAL_W-1:0]        quot_lo;

  // Number of dimensions in use, kept as the index of the last one.
  always_comb begin
    if (dim_cnt_q == '0) begin
      last_pos = '0;
    end else if (dim_cnt_q > CFG_W'(MAX_DIMS)) begin
      last_pos = DIM_W'(MAX_DIMS - 1);
    end else begin
      last_pos = DIM_W'(dim_cnt_q - 1'b1);
    end
  end

  // One table read port: the order table picks the dimension, except while
  // elements are built in dimension order.
  assign ord_pos   = (state_q == S_IDLE) ? last_pos : pos_q;
  assign ord_dim   = order_q[ord_pos];
  assign sel_dim   = (state_q == S_DIFF) ? pos_q : ord_dim;
  assign sel_cnt   = count_q[sel_dim];
  assign sel_step  = step_q[sel_dim];
  assign sel_start = start_q[sel_dim];
  assign sel_end   = end_q[sel_dim];
  assign slow_fin  = (sel_cnt >= sel_step);
  assign small_span = (sel_step <= STEP_W'(1));
  assign is_last   = (pos_q == last_pos);

  // The first dimensions in use must name each of them exactly once.
  always_comb begin
    perm_ok = 1'b1;
    for (int a = 0; a < MAX_DIMS; a++) begin
      if (DIM_W'(a) <= last_pos) begin
        if (order_q[a] > last_pos) begin
          perm_ok = 1'b0;
        end
        for (int b = a + 1; b < MAX_DIMS; b++) begin
          if ((DIM_W'(b) <= last_pos) && (order_q[a] == order_q[b])) begin
            perm_ok = 1'b0;
          end
        end
      end
    end
  end

  // Mixed-radix advance, one order position per cycle.
  assign adv_val  = sel_cnt + {{(STEP_W-1){1'b0}}, carry_q};
  assign adv_wrap = !is_last && (adv_val >= sel_step);

  // Arithmetic for one element.
  assign prod_full = $signed({1'b0, idx_q}) * diff_q;
  assign prod_neg  = '0 - prod_q;
  assign quot_lo   = div_rsp_i.quotient[VAL_W-1:0];

  always_comb begin
    elem.element_value     = s_q + qs_q;
    elem.element_dimension = pos_q;
    elem.last_element      = is_last;
    elem.sweep_done        = 1'b0;
    elem.status            = ST_OK;
  end

  // Single result chosen when a command is taken.
  always_comb begin
    res_d.element_value     = '0;
    res_d.element_dimension = '0;
    res_d.last_element      = 1'b1;
    res_d.sweep_done        = 1'b1;
    res_d.status            = ST_OK;
    if (cmd_i.op == OP_RESTART) begin
      if (perm_ok) begin
        res_d.sweep_done = (sel_step == '0);
      end else begin
        res_d.status = ST_NOT_PERM;
      end
    end else if (!ready_q) begin
      res_d.status = ST_NOT_STARTED;
    end
  end

  // Sequencer: next state and handshakes.
  always_comb begin
    state_d                = state_q;
    cmd_pop_o              = 1'b0;
    div_req_o.start        = 1'b0;
    div_req_o.dividend     = prod_q[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_q[MAG_W-1:0];
    div_req_o.divisor      = dsr_q;
    push_en                = 1'b0;
    push_data              = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_LOAD, OP_ORDER: state_d = S_IDLE;
            OP_RESTART:        state_d = S_SINGLE;
            OP_NEXT:           state_d = (ready_q && !slow_fin) ? S_DIFF : S_SINGLE;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_SINGLE: begin
        push_en = !oq_full;
        if (!oq_full) begin
          state_d = S_IDLE;
        end
      end
      S_DIFF: begin
        state_d = small_span ? S_EMIT : S_MUL;
      end
      S_MUL: begin
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_req_o.start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        push_en   = !oq_full;
        push_data = elem;
        if (!oq_full) begin
          state_d = is_last ? S_ADV : S_DIFF;
        end
      end
      S_ADV: begin
        if (is_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state, tables and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
        step_q[i]  <= '0;
        order_q[i] <= '0;
        count_q[i] <= '0;
      end
      ready_q   <= 1'b0;
      dim_cnt_q <= CFG_W'(1);
      pos_q     <= '0;
      carry_q   <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        unique case (cmd_i.op)
          OP_LOAD: begin
            start_q[cmd_i.slot] <= cmd_i.start_value;
            end_q[cmd_i.slot]   <= cmd_i.end_value;
            step_q[cmd_i.slot]  <= cmd_i.step_total;
            ready_q             <= 1'b0;
          end
          OP_ORDER: begin
            order_q[cmd_i.slot] <= cmd_i.order_dim;
            ready_q             <= 1'b0;
          end
          OP_RESTART: begin
            ready_q <= perm_ok;
            if (perm_ok) begin
              for (int i = 0; i < MAX_DIMS; i++) begin
                count_q[i] <= '0;
              end
            end
          end
          OP_NEXT: begin
            pos_q <= '0;
          end
          default: ;
        endcase
      end
      if ((state_q == S_EMIT) && !oq_full) begin
        pos_q   <= is_last ? '0 : pos_q + 1'b1;
        carry_q <= 1'b1;
      end
      if (state_q == S_ADV) begin
        count_q[sel_dim] <= adv_wrap ? '0 : adv_val;
        carry_q          <= adv_wrap;
        pos_q            <= pos_q + 1'b1;
      end
      if (cfg_we_i) begin
        dim_cnt_q <= cfg_wdata_i;
        ready_q   <= 1'b0;
      end
    end
  end

  // Element datapath.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
    if (state_q == S_DIFF) begin
      s_q    <= sel_start;
      diff_q <= $signed({sel_end[VAL_W-1], sel_end}) - $signed({sel_start[VAL_W-1], sel_start});
      idx_q  <= sel_cnt;
      dsr_q  <= sel_step - 1'b1;
      qs_q   <= '0;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
    if (state_q == S_DIV_GO) begin
      neg_q <= prod_q[PROD_W-1];
    end
    if ((state_q == S_DIV_WAIT) && div_rsp_i.done) begin
      qs_q <= neg_q ? VAL_W'(0) - quot_lo : quot_lo;
    end
  end

  // Result queue control.
  assign oq_full    = (oq_cnt_q == OUTQ_CNT_W'(OUTQ_DEPTH));
  assign empty      = (oq_cnt_q == '0);
  assign oq_pop     = pop && !empty;
  assign out_data_o = outq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (push_en) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      if (push_en && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 1'b1;
      end else if (oq_pop && !push_en) begin
        oq_cnt_q <= oq_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      outq_q[oq_wr_q] <= push_data;
    end
  end

endmodule

@@ sv/grid_sweep_vector_generator.sv @@
// Channel  | Direction | Handshake          | Payload
// input    | in        | push / full        | in_data_i  (gsv_in_t)
// result   | out       | empty / pop        | out_data_o (gsv_out_t)
// config   | in        | cfg_we_i           | cfg_wdata_i (dimension count)
//
// Load and order items are handled in the back end's idle state; a restart or
// a vector request with a single result also passes the single-result state.
// Vector elements use the shared divider, which retires two quotient bits per
// cycle, unless their dimension has a step total of one or less.
// Reset clears the tables, counters and both queues; the sweep is not started.
// A full result queue stalls the back end only; the two-entry command queue
// keeps taking items until it fills.
module grid_sweep_vector_generator import gsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  gsv_in_t          in_data_i,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output gsv_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic         cmd_valid;
  logic         cmd_pop;
  gsv_cmd_t     cmd;
  gsv_div_req_t div_req;
  gsv_div_rsp_t div_rsp;

  // Front end: accepts and decodes items.
  gsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_data_i   (in_data_i),
    .full        (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // Shared divider for the interpolation quotient.
  gsv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Back end: tables, sweep counters and result queue.
  gsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data_o)
  );

  // The divider is never restarted while a quotient is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The back end only takes a command the front end holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  // An error result is always a single, finished result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_data_o.status != ST_OK)) |->
      (out_data_o.sweep_done && out_data_o.last_element))
    else $error("error result is not a single done result");

  // A done result a vector element never carries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.sweep_done) |->
      (out_data_o.element_value == '0 && out_data_o.element_dimension == '0))
    else $error("done result carries element data");

endmodule
